### sv/etfla_pkg.sv
// ----------------------------------------------------------------------------
// etfla_pkg
// Shared types and codes for the epoch-tagged free list allocator.
// ----------------------------------------------------------------------------
package etfla_pkg;

	typedef enum logic [1:0] {
		KIND_ALLOC     = 2'd0,
		KIND_RELEASE   = 2'd1,
		KIND_QUERY     = 2'd2,
		KIND_NEW_EPOCH = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic exec;
		logic clr_step;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic wrap;
		logic clr_last;
	} sts_t;

endpackage

### sv/etfla_dp.sv
// ----------------------------------------------------------------------------
// etfla_dp
// Datapath: tag memory, free stack memory, pointers, epoch and result register.
// ----------------------------------------------------------------------------
module etfla_dp import etfla_pkg::*; #(
	parameter int MAX_SLOTS  = 1024,
	parameter int EPOCH_BITS = 8,
	localparam int ID_W  = $clog2(MAX_SLOTS),
	localparam int CNT_W = $clog2(MAX_SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic [1:0]       kind,
	input  logic [ID_W-1:0]  slot_id,
	output logic [ID_W-1:0]  granted_slot,
	output logic [1:0]       status,
	output logic             is_live,
	output logic [CNT_W-1:0] live_count
);

	localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(MAX_SLOTS);

	logic [EPOCH_BITS-1:0] tag_mem [MAX_SLOTS];
	logic [ID_W-1:0]       stk_mem [MAX_SLOTS];

	logic [CNT_W-1:0]      pool_size_q;
	logic [CNT_W-1:0]      depth_q, bump_q, count_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [ID_W-1:0]       clr_idx_q;
	kind_t                 kind_q;
	logic [ID_W-1:0]       id_q;
	logic [EPOCH_BITS-1:0] tag_rd_q;
	logic [ID_W-1:0]       stk_rd_q;
	logic [ID_W-1:0]       granted_q;
	status_t               status_q;
	logic                  live_q;

	logic [CNT_W-1:0]      eff_size;
	logic [CNT_W-1:0]      depth_m1;
	logic                  id_ok, tag_hit, wrap;

	logic [CNT_W-1:0]      depth_d, bump_d, count_d;
	logic [EPOCH_BITS-1:0] epoch_d;
	logic [ID_W-1:0]       granted_d;
	status_t               status_d;
	logic                  live_d;
	logic                  tag_we, stk_we;
	logic [ID_W-1:0]       tag_wa;
	logic [EPOCH_BITS-1:0] tag_wd;

	// A pool size of zero behaves as one, and anything above the pool as the pool.
	always_comb begin
		if (pool_size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (pool_size_q > SIZE_MAX) begin
			eff_size = SIZE_MAX;
		end else begin
			eff_size = pool_size_q;
		end
	end

	assign depth_m1 = depth_q - CNT_W'(1);
	assign id_ok    = CNT_W'(id_q) < eff_size;
	assign tag_hit  = tag_rd_q == epoch_q;
	assign wrap     = (kind_q == KIND_NEW_EPOCH) && (&epoch_q);

	always_comb begin
		granted_d = '0;
		status_d  = ST_OK;
		live_d    = 1'b0;
		depth_d   = depth_q;
		bump_d    = bump_q;
		count_d   = count_q;
		epoch_d   = epoch_q;
		tag_we    = 1'b0;
		tag_wa    = id_q;
		tag_wd    = '0;
		stk_we    = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				if (depth_q != '0) begin
					depth_d   = depth_m1;
					tag_we    = 1'b1;
					tag_wa    = stk_rd_q;
					tag_wd    = epoch_q;
					count_d   = count_q + CNT_W'(1);
					granted_d = stk_rd_q;
				end else if (bump_q < eff_size) begin
					bump_d    = bump_q + CNT_W'(1);
					tag_we    = 1'b1;
					tag_wa    = bump_q[ID_W-1:0];
					tag_wd    = epoch_q;
					count_d   = count_q + CNT_W'(1);
					granted_d = bump_q[ID_W-1:0];
				end else begin
					status_d = ST_FULL;
				end
			end
			KIND_RELEASE: begin
				if (!id_ok) begin
					status_d = ST_RANGE;
				end else if (tag_hit) begin
					tag_we = 1'b1;
					if (depth_q < SIZE_MAX) begin
						stk_we  = 1'b1;
						depth_d = depth_q + CNT_W'(1);
					end
					if (count_q != '0) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			KIND_QUERY: begin
				live_d = id_ok && tag_hit;
			end
			KIND_NEW_EPOCH: begin
				depth_d = '0;
				bump_d  = '0;
				count_d = '0;
				epoch_d = wrap ? EPOCH_BITS'(1) : epoch_q + EPOCH_BITS'(1);
			end
			default: begin
			end
		endcase
	end

	// Tag memory: one write port shared by the clearing pass and execution.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			tag_mem[clr_idx_q] <= '0;
		end else if (cmd.exec && tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (cmd.accept) begin
			tag_rd_q <= tag_mem[slot_id];
		end
	end

	// The stack top is read at acceptance so it is ready for execution.
	always_ff @(posedge clk) begin
		if (cmd.exec && stk_we) begin
			stk_mem[depth_q[ID_W-1:0]] <= id_q;
		end
		if (cmd.accept) begin
			stk_rd_q <= stk_mem[depth_m1[ID_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind_t'(kind);
			id_q   <= slot_id;
		end
		if (cmd.exec) begin
			granted_q <= granted_d;
			status_q  <= status_d;
			live_q    <= live_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= SIZE_MAX;
			depth_q     <= '0;
			bump_q      <= '0;
			count_q     <= '0;
			epoch_q     <= EPOCH_BITS'(1);
			clr_idx_q   <= '0;
		end else begin
			if (cfg_we) begin
				pool_size_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				depth_q <= depth_d;
				bump_q  <= bump_d;
				count_q <= count_d;
				epoch_q <= epoch_d;
			end
			if (cmd.clr_step) begin
				clr_idx_q <= sts.clr_last ? '0 : clr_idx_q + ID_W'(1);
			end
		end
	end

	assign sts.wrap     = wrap;
	assign sts.clr_last = clr_idx_q == ID_W'(MAX_SLOTS - 1);

	assign granted_slot = granted_q;
	assign status       = status_q;
	assign is_live      = live_q;
	assign live_count   = count_q;

`ifndef SYNTHESIS
	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("current epoch reached zero");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SIZE_MAX)
		else $error("live count exceeds the pool");

	a_wrap_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && wrap |=> epoch_q == EPOCH_BITS'(1))
		else $error("epoch did not restart at one after wrap");
`endif

endmodule

### sv/etfla_ctrl.sv
// ----------------------------------------------------------------------------
// etfla_ctrl
// Controller: sequences clearing, request acceptance, execution and output.
// ----------------------------------------------------------------------------
module etfla_ctrl import etfla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign req_stall    = state_q != S_IDLE;
	assign cmd.accept   = (state_q == S_IDLE) && req_valid;
	assign cmd.exec     = (state_q == S_EXEC) && out_free;
	assign cmd.clr_step = state_q == S_CLEAR;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_d = sts.wrap ? S_CLEAR : S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_EXEC)
		else $error("accepted request did not move to execution");

	a_exec_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp_valid_q)
		else $error("executed request produced no response");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_EXEC))
		else $error("response raised outside execution");

	a_wrap_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && sts.wrap |=> state_q == S_CLEAR)
		else $error("epoch wrap did not start a clearing pass");
`endif

endmodule

### sv/epoch_tagged_free_list_allocator.sv
// ----------------------------------------------------------------------------
// epoch_tagged_free_list_allocator
// Slot allocator with a LIFO free stack, a bump pointer and epoch-tagged slots.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_stall with kind and slot_id; each request
// gives exactly one response on rsp_valid/rsp_stall carrying granted_slot,
// status, is_live and live_count. cfg_we writes pool_size from cfg_wdata and
// is meant for times when no request is in flight.
// A request is taken in the idle state; its tag and free stack reads start at
// that edge; it then executes in the execution state, loading the response
// register once that register is free. A new request is taken only after the
// previous one has executed, as the registered read of the tag and stack
// memories is followed by their write-back.
// A request can be accepted while the previous response still waits; if the
// receiver keeps stalling, execution holds until the response register frees.
// After reset, and after a new-epoch request that wraps the epoch counter, a
// clearing pass zeroes all MAX_SLOTS tag memory entries, one entry per cycle,
// while req_stall stays high. Reset sets pool_size to MAX_SLOTS and epoch 1.
// ----------------------------------------------------------------------------
module epoch_tagged_free_list_allocator import etfla_pkg::*; #(
	parameter int MAX_SLOTS  = 1024,
	parameter int EPOCH_BITS = 8,
	localparam int ID_W  = $clog2(MAX_SLOTS),
	localparam int CNT_W = $clog2(MAX_SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       kind,
	input  logic [ID_W-1:0]  slot_id,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [ID_W-1:0]  granted_slot,
	output logic [1:0]       status,
	output logic             is_live,
	output logic [CNT_W-1:0] live_count
);

	cmd_t cmd;
	sts_t sts;

	etfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	etfla_dp #(
		.MAX_SLOTS  (MAX_SLOTS),
		.EPOCH_BITS (EPOCH_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.kind         (kind),
		.slot_id      (slot_id),
		.granted_slot (granted_slot),
		.status       (status),
		.is_live      (is_live),
		.live_count   (live_count)
	);

endmodule
